FILE: rtl/pf_pkg.sv
// shared types, codes and helpers for the playfair encrypt unit
package pf_pkg;

  localparam int unsigned LETTER_W        = 5;
  localparam int unsigned ALPHABET        = 26;
  localparam int unsigned SQUARE_SIDE_DEF = 5;

  typedef logic [LETTER_W-1:0] letter_t;

  localparam letter_t LETTER_I    = letter_t'(8);
  localparam letter_t LETTER_J    = letter_t'(9);
  localparam letter_t LETTER_LAST = letter_t'(ALPHABET - 1);

  // op codes of an input beat
  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_PAIR   = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    letter_t    letter_a;
    letter_t    letter_b;
  } in_item_t;

  typedef struct packed {
    letter_t cipher_a;
    letter_t cipher_b;
  } out_item_t;

  // control from the sequencer to every lane
  typedef struct packed {
    logic    wr_en;
    letter_t wr_letter;
    letter_t key_a;
    letter_t key_b;
  } lane_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_FILL = 3'b100
  } state_t;

  // j shares the cell of i
  function automatic letter_t fold(input letter_t c);
    return (c == LETTER_J) ? LETTER_I : c;
  endfunction

endpackage

FILE: rtl/pf_lane.sv
// one key square cell: storage, letter match and target pick
module pf_lane #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned CNT_W    = 5,
  parameter int unsigned POS_W    = 5
) (
  input  logic              clk,
  input  pf_pkg::lane_ctl_t ctl,
  input  logic [CNT_W-1:0]  fill_cnt,
  input  logic [POS_W-1:0]  tgt_a,
  input  logic [POS_W-1:0]  tgt_b,
  output logic              hit_a,
  output logic              hit_b,
  output pf_pkg::letter_t   pick_a,
  output pf_pkg::letter_t   pick_b
);

  pf_pkg::letter_t cell_r;

  // the cell takes the next placed letter when the fill pointer reaches it
  always_ff @(posedge clk) begin
    if (ctl.wr_en && (fill_cnt == CNT_W'(CELL_IDX))) begin
      cell_r <= ctl.wr_letter;
    end
  end

  // plaintext letter lookup
  assign hit_a = (cell_r == ctl.key_a);
  assign hit_b = (cell_r == ctl.key_b);

  // present the letter only when this cell is the cipher target
  assign pick_a = (tgt_a == POS_W'(CELL_IDX)) ? cell_r : '0;
  assign pick_b = (tgt_b == POS_W'(CELL_IDX)) ? cell_r : '0;

endmodule

FILE: rtl/pf_merge.sv
// merge of lane results: match positions and picked cipher letters
module pf_merge #(
  parameter int unsigned CELLS = 25,
  parameter int unsigned POS_W = 5
) (
  input  logic [CELLS-1:0] hit_a,
  input  logic [CELLS-1:0] hit_b,
  input  pf_pkg::letter_t  pick_a [CELLS],
  input  pf_pkg::letter_t  pick_b [CELLS],
  output logic [POS_W-1:0] pos_a,
  output logic [POS_W-1:0] pos_b,
  output pf_pkg::letter_t  let_a,
  output pf_pkg::letter_t  let_b
);

  // letters are unique in the square, so an or of the hit indices encodes
  // the match; no hit gives position zero
  always_comb begin
    pos_a = '0;
    pos_b = '0;
    let_a = '0;
    let_b = '0;
    for (int k = 0; k < CELLS; k++) begin
      if (hit_a[k]) pos_a = pos_a | POS_W'(k);
      if (hit_b[k]) pos_b = pos_b | POS_W'(k);
      let_a = let_a | pick_a[k];
      let_b = let_b | pick_b[k];
    end
  end

endmodule

FILE: rtl/pf_rule.sv
// playfair rules: cipher cell positions from the two plaintext positions
module pf_rule #(
  parameter int unsigned SIDE  = 5,
  parameter int unsigned POS_W = 5
) (
  input  logic [POS_W-1:0] pos_a,
  input  logic [POS_W-1:0] pos_b,
  output logic [POS_W-1:0] tgt_a,
  output logic [POS_W-1:0] tgt_b
);

  localparam logic [POS_W-1:0] SIDE_P    = POS_W'(SIDE);
  localparam logic [POS_W-1:0] LAST_COL  = POS_W'(SIDE - 1);
  localparam logic [POS_W-1:0] LAST_BASE = POS_W'((SIDE - 1) * SIDE);

  logic [POS_W-1:0] base_a, base_b, col_a, col_b;
  logic [POS_W-1:0] ncol_a, ncol_b, nbase_a, nbase_b;

  // split a position into row start and column
  always_comb begin
    base_a = '0;
    base_b = '0;
    for (int r = 1; r < SIDE; r++) begin
      if (pos_a >= POS_W'(r * SIDE)) base_a = POS_W'(r * SIDE);
      if (pos_b >= POS_W'(r * SIDE)) base_b = POS_W'(r * SIDE);
    end
  end

  assign col_a = pos_a - base_a;
  assign col_b = pos_b - base_b;

  // wrapped neighbors to the right and below
  assign ncol_a  = (col_a == LAST_COL) ? '0 : col_a + 1'b1;
  assign ncol_b  = (col_b == LAST_COL) ? '0 : col_b + 1'b1;
  assign nbase_a = (base_a == LAST_BASE) ? '0 : base_a + SIDE_P;
  assign nbase_b = (base_b == LAST_BASE) ? '0 : base_b + SIDE_P;

  // same row, then same column, then rectangle
  always_comb begin
    if (base_a == base_b) begin
      tgt_a = base_a + ncol_a;
      tgt_b = base_b + ncol_b;
    end else if (col_a == col_b) begin
      tgt_a = nbase_a + col_a;
      tgt_b = nbase_b + col_b;
    end else begin
      tgt_a = base_a + col_b;
      tgt_b = base_b + col_a;
    end
  end

endmodule

FILE: rtl/playfair_cipher_encrypt_unit.sv
// playfair encrypt unit: key square build and pair encryption over cell lanes
//
//   channel | direction | payload            | handshake
//   in_     | input     | op, letter_a/b     | in_valid, in_stall
//   out_    | output    | cipher_a/b         | out_valid, out_stall
//
// a key letter beat is handled as it is accepted; for a letter pair the lane
// compares find both letters and their positions are registered, then the rule
// and the lane pick load the output register in the lookup state.
// the finish beat walks the alphabet through the shared place logic, one
// letter a cycle, with in_stall high.
// synchronous reset clears the seen set, the fill pointer and the ready flag;
// the square cells hold garbage until written.
// a stalled result stays in the output register; a pair waits in the
// lookup stage until that register frees up.
module playfair_cipher_encrypt_unit #(
  parameter int unsigned SQUARE_SIDE = pf_pkg::SQUARE_SIDE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pf_pkg::in_item_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output pf_pkg::out_item_t out_data
);

  localparam int unsigned CELLS = SQUARE_SIDE * SQUARE_SIDE;
  localparam int unsigned POS_W = $clog2(CELLS);
  localparam int unsigned CNT_W = $clog2(CELLS + 1);
  localparam logic [CNT_W-1:0] CELLS_C = CNT_W'(CELLS);

  pf_pkg::state_t state_r, state_nxt;
  logic [pf_pkg::ALPHABET-1:0] seen_r, seen_nxt;
  logic [CNT_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic ready_r, ready_nxt;
  pf_pkg::letter_t fill_let_r, fill_let_nxt;
  logic [POS_W-1:0] pos_a_r, pos_b_r;
  logic out_valid_r, out_valid_nxt;
  pf_pkg::out_item_t out_data_r;

  logic in_acc, load_out;
  logic letters_ok;
  pf_pkg::letter_t key_a, key_b, place_let;
  logic place_try, do_place;
  pf_pkg::lane_ctl_t ctl;

  logic [CELLS-1:0] hit_a, hit_b;
  pf_pkg::letter_t pick_a [CELLS];
  pf_pkg::letter_t pick_b [CELLS];
  logic [POS_W-1:0] pos_a, pos_b, tgt_a, tgt_b;
  pf_pkg::letter_t let_a, let_b;

  // handshake
  assign in_stall  = (state_r != pf_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_out  = (state_r == pf_pkg::ST_LOOK) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign letters_ok = (in_data.letter_a < pf_pkg::LETTER_W'(pf_pkg::ALPHABET))
                   && (in_data.letter_b < pf_pkg::LETTER_W'(pf_pkg::ALPHABET));
  assign key_a = pf_pkg::fold(in_data.letter_a);
  assign key_b = pf_pkg::fold(in_data.letter_b);

  // shared place logic for key letters and the finish walk
  assign place_let = (state_r == pf_pkg::ST_FILL) ? fill_let_r : key_a;
  assign place_try = (in_acc && (in_data.op == pf_pkg::OP_KEY) && !ready_r
                      && (in_data.letter_a < pf_pkg::LETTER_W'(pf_pkg::ALPHABET)))
                  || ((state_r == pf_pkg::ST_FILL) && (fill_let_r != pf_pkg::LETTER_J));
  assign do_place  = place_try && !seen_r[place_let] && (fill_cnt_r < CELLS_C);

  assign ctl.wr_en     = do_place;
  assign ctl.wr_letter = place_let;
  assign ctl.key_a     = key_a;
  assign ctl.key_b     = key_b;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    seen_nxt      = seen_r;
    fill_cnt_nxt  = fill_cnt_r;
    ready_nxt     = ready_r;
    fill_let_nxt  = fill_let_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (do_place) begin
      seen_nxt[place_let] = 1'b1;
      fill_cnt_nxt        = fill_cnt_r + 1'b1;
    end
    case (state_r)
      pf_pkg::ST_IDLE: begin
        if (in_acc) begin
          if ((in_data.op == pf_pkg::OP_FINISH) && !ready_r) begin
            state_nxt    = pf_pkg::ST_FILL;
            fill_let_nxt = '0;
          end else if ((in_data.op == pf_pkg::OP_PAIR) && ready_r && letters_ok) begin
            state_nxt = pf_pkg::ST_LOOK;
          end
        end
      end
      pf_pkg::ST_LOOK: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = pf_pkg::ST_IDLE;
        end
      end
      pf_pkg::ST_FILL: begin
        fill_let_nxt = fill_let_r + 1'b1;
        if (fill_let_r == pf_pkg::LETTER_LAST) begin
          ready_nxt = 1'b1;
          state_nxt = pf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pf_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pf_pkg::ST_IDLE;
      seen_r      <= '0;
      fill_cnt_r  <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fill_let_r <= fill_let_nxt;
    if (in_acc) begin
      pos_a_r <= pos_a;
      pos_b_r <= pos_b;
    end
    if (load_out) begin
      out_data_r.cipher_a <= let_a;
      out_data_r.cipher_b <= let_b;
    end
  end

  // cell lanes
  for (genvar k = 0; k < CELLS; k++) begin : g_lane
    pf_lane #(
      .CELL_IDX (k),
      .CNT_W    (CNT_W),
      .POS_W    (POS_W)
    ) u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .fill_cnt (fill_cnt_r),
      .tgt_a    (tgt_a),
      .tgt_b    (tgt_b),
      .hit_a    (hit_a[k]),
      .hit_b    (hit_b[k]),
      .pick_a   (pick_a[k]),
      .pick_b   (pick_b[k])
    );
  end

  // merge of lane hits and picks
  pf_merge #(
    .CELLS (CELLS),
    .POS_W (POS_W)
  ) u_merge (
    .hit_a  (hit_a),
    .hit_b  (hit_b),
    .pick_a (pick_a),
    .pick_b (pick_b),
    .pos_a  (pos_a),
    .pos_b  (pos_b),
    .let_a  (let_a),
    .let_b  (let_b)
  );

  // cipher positions from the stored plaintext positions
  pf_rule #(
    .SIDE  (SQUARE_SIDE),
    .POS_W (POS_W)
  ) u_rule (
    .pos_a (pos_a_r),
    .pos_b (pos_b_r),
    .tgt_a (tgt_a),
    .tgt_b (tgt_b)
  );

  // a new result only comes out of the lookup stage
  a_out_from_look: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == pf_pkg::ST_LOOK))
    else $error("result without a lookup");

  // once finished the square stays finished
  a_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |=> ready_r)
    else $error("ready flag dropped");

  // the finish walk leaves every cell filled
  a_fill_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pf_pkg::ST_FILL) && (fill_let_r == pf_pkg::LETTER_LAST)
    |=> (fill_cnt_r == CELLS_C) && ready_r)
    else $error("square not full after finish");

  // a pair is only looked up in a finished square
  a_look_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pf_pkg::ST_LOOK) |-> ready_r)
    else $error("lookup before square finished");

endmodule

FILE: tb/playfair_cipher_encrypt_unit_tb.sv
// testbench for the playfair encrypt unit: directed table, random pairs, predictor scoreboard
module playfair_cipher_encrypt_unit_tb;

  localparam int SIDE         = pf_pkg::SQUARE_SIDE_DEF;
  localparam int CELLS        = SIDE * SIDE;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PAIRS   = 1100;
  localparam int DIR_N        = 24;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int PAUSE_AT     = 1000;

  // op 3 has no meaning in the block
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    pf_pkg::in_item_t  beat;
    logic              typed;
    pf_pkg::out_item_t want;
  } dir_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  pf_pkg::in_item_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  pf_pkg::out_item_t out_data;

  // predictor state
  pf_pkg::letter_t key_sq [CELLS];
  logic [25:0]     seen_set;
  int              cells_filled;
  bit              sq_ready;

  pf_pkg::out_item_t cipher_q [$];
  int                mismatches   = 0;
  int                ciphers_seen = 0;
  int                pairs_sent   = 0;
  dir_row_t          dir_tab [DIR_N];

  playfair_cipher_encrypt_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop for a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // j shares the cell of i
  function automatic pf_pkg::letter_t merge_j(input pf_pkg::letter_t c);
    return (c == pf_pkg::LETTER_J) ? pf_pkg::LETTER_I : c;
  endfunction

  function automatic void key_place(input pf_pkg::letter_t c);
    if (seen_set[c] || cells_filled >= CELLS) return;
    key_sq[cells_filled] = c;
    seen_set[c] = 1'b1;
    cells_filled++;
  endfunction

  function automatic int cell_of(input pf_pkg::letter_t c);
    for (int k = 0; k < CELLS; k++) begin
      if (key_sq[k] == c) return k;
    end
    return 0;
  endfunction

  // advance the predictor by one beat; returns 1 when a cipher pair comes out
  function automatic bit encrypt_beat(input pf_pkg::in_item_t it,
                                      output pf_pkg::out_item_t res);
    int pa, pb, ra, ca, rb, cb;
    res = '0;
    case (it.op)
      pf_pkg::OP_KEY: begin
        if (!sq_ready && it.letter_a < pf_pkg::ALPHABET) key_place(merge_j(it.letter_a));
      end
      pf_pkg::OP_FINISH: begin
        if (!sq_ready) begin
          for (int c = 0; c < pf_pkg::ALPHABET; c++) begin
            if (pf_pkg::letter_t'(c) != pf_pkg::LETTER_J) key_place(pf_pkg::letter_t'(c));
          end
          sq_ready = 1'b1;
        end
      end
      pf_pkg::OP_PAIR: begin
        if (sq_ready && it.letter_a < pf_pkg::ALPHABET && it.letter_b < pf_pkg::ALPHABET) begin
          pa = cell_of(merge_j(it.letter_a));
          pb = cell_of(merge_j(it.letter_b));
          ra = pa / SIDE;
          ca = pa % SIDE;
          rb = pb / SIDE;
          cb = pb % SIDE;
          if (ra == rb) begin
            res.cipher_a = key_sq[ra * SIDE + (ca + 1) % SIDE];
            res.cipher_b = key_sq[rb * SIDE + (cb + 1) % SIDE];
          end else if (ca == cb) begin
            res.cipher_a = key_sq[((ra + 1) % SIDE) * SIDE + ca];
            res.cipher_b = key_sq[((rb + 1) % SIDE) * SIDE + cb];
          end else begin
            res.cipher_a = key_sq[ra * SIDE + cb];
            res.cipher_b = key_sq[rb * SIDE + ca];
          end
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic dir_row_t row(input logic [1:0] op, input int a, input int b,
                                   input bit typed, input int ea, input int eb);
    dir_row_t r;
    r.beat  = '{op, pf_pkg::letter_t'(a), pf_pkg::letter_t'(b)};
    r.typed = typed;
    r.want  = '{pf_pkg::letter_t'(ea), pf_pkg::letter_t'(eb)};
    return r;
  endfunction

  function automatic pf_pkg::letter_t any_letter();
    if ($urandom_range(9) == 0) return pf_pkg::LETTER_J;
    return pf_pkg::letter_t'($urandom_range(25));
  endfunction

  function automatic pf_pkg::letter_t bad_letter();
    return pf_pkg::letter_t'($urandom_range(31, 26));
  endfunction

  // random beat after the square is done; mostly well-formed pairs
  function automatic pf_pkg::in_item_t random_beat(output bit is_pair);
    pf_pkg::in_item_t it;
    int               pick;
    pick = $urandom_range(99);
    is_pair = 1'b0;
    if (pick < 80) begin
      it = '{pf_pkg::OP_PAIR, any_letter(), any_letter()};
      is_pair = 1'b1;
    end else if (pick < 86) begin
      if ($urandom_range(1)) it = '{pf_pkg::OP_PAIR, bad_letter(), any_letter()};
      else it = '{pf_pkg::OP_PAIR, any_letter(), bad_letter()};
    end else if (pick < 91) begin
      it = '{OP_UNUSED, pf_pkg::letter_t'($urandom_range(31)),
             pf_pkg::letter_t'($urandom_range(31))};
    end else if (pick < 96) begin
      it = '{pf_pkg::OP_KEY, pf_pkg::letter_t'($urandom_range(31)),
             pf_pkg::letter_t'($urandom_range(31))};
    end else begin
      it = '{pf_pkg::OP_FINISH, pf_pkg::letter_t'($urandom_range(31)),
             pf_pkg::letter_t'($urandom_range(31))};
    end
    return it;
  endfunction

  // drive one beat, with a random idle gap ahead of it, and wait for acceptance
  task automatic offer_beat(input pf_pkg::in_item_t it, input bit idle_ok);
    while (idle_ok && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_beat(input pf_pkg::in_item_t it, input bit typed,
                           input pf_pkg::out_item_t want, input bit idle_ok);
    pf_pkg::out_item_t res;
    bit                has;
    offer_beat(it, idle_ok);
    has = encrypt_beat(it, res);
    if (typed) cipher_q.push_back(want);
    else if (has) cipher_q.push_back(res);
  endtask

  // result side: check each beat, choose the next stall
  initial begin : result_side
    pf_pkg::out_item_t want;
    int                hold_left;
    bit                held;
    bit                stall_next;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (cipher_q.size() == 0) begin
          $display("%0t: unexpected cipher beat, expected none, actual %0d/%0d",
                   $time, out_data.cipher_a, out_data.cipher_b);
          mismatches++;
        end else begin
          want = cipher_q.pop_front();
          if (out_data.cipher_a !== want.cipher_a) begin
            $display("%0t: cipher_a mismatch, expected %0d, actual %0d",
                     $time, want.cipher_a, out_data.cipher_a);
            mismatches++;
          end
          if (out_data.cipher_b !== want.cipher_b) begin
            $display("%0t: cipher_b mismatch, expected %0d, actual %0d",
                     $time, want.cipher_b, out_data.cipher_b);
            mismatches++;
          end
        end
        ciphers_seen++;
      end
      // long hold-off once, so the block backs up into its input
      if (!held && ciphers_seen >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        stall_next = 1'b1;
        hold_left--;
      end else if (ciphers_seen >= 700 && ciphers_seen < 1000) begin
        stall_next = 1'b0;
      end else begin
        stall_next = ($urandom_range(99) < 14);
      end
      out_stall <= stall_next;
    end
  end

  // stimulus
  initial begin : beat_source
    pf_pkg::in_item_t it;
    bit               is_pair;
    bit               paused;
    paused = 1'b0;
    seen_set     = '0;
    cells_filled = 0;
    sq_ready     = 1'b0;
    for (int k = 0; k < CELLS; k++) key_sq[k] = '0;

    // key z j a z i gives rows: z i a b c / d e f g h / k l m n o / p q r s t / u v w x y
    dir_tab = '{
      row(pf_pkg::OP_PAIR,    0,  1, 0, 0, 0),   // encrypt before finish
      row(pf_pkg::OP_KEY,    25,  0, 0, 0, 0),
      row(pf_pkg::OP_KEY,     9,  0, 0, 0, 0),   // j lands as i
      row(pf_pkg::OP_KEY,     0,  0, 0, 0, 0),
      row(pf_pkg::OP_KEY,    25,  0, 0, 0, 0),   // repeat letter
      row(pf_pkg::OP_KEY,     8,  0, 0, 0, 0),   // i already placed through j
      row(pf_pkg::OP_KEY,    26,  0, 0, 0, 0),   // out of range
      row(pf_pkg::OP_KEY,    31, 31, 0, 0, 0),
      row(pf_pkg::OP_PAIR,   31, 31, 0, 0, 0),
      row(OP_UNUSED,          0,  0, 0, 0, 0),
      row(pf_pkg::OP_FINISH,  0,  0, 0, 0, 0),
      row(pf_pkg::OP_FINISH, 31, 31, 0, 0, 0),   // repeated finish
      row(pf_pkg::OP_KEY,     5,  0, 0, 0, 0),   // key letter after finish
      row(pf_pkg::OP_PAIR,   25, 25, 1, 8, 8),   // equal letters, same row rule
      row(pf_pkg::OP_PAIR,    9,  0, 1, 0, 1),   // j in a pair
      row(pf_pkg::OP_PAIR,    2, 24, 1, 7, 2),   // same column, wraps to top
      row(pf_pkg::OP_PAIR,   25, 24, 1, 2, 20),  // rectangle, opposite corners
      row(pf_pkg::OP_PAIR,    0,  0, 0, 0, 0),
      row(pf_pkg::OP_PAIR,    9,  8, 0, 0, 0),
      row(pf_pkg::OP_PAIR,   26,  0, 0, 0, 0),   // out of range
      row(pf_pkg::OP_PAIR,    0, 31, 0, 0, 0),
      row(OP_UNUSED,         31, 31, 0, 0, 0),
      row(pf_pkg::OP_PAIR,   24, 24, 0, 0, 0),   // row wraps to first column
      row(pf_pkg::OP_PAIR,    3, 13, 0, 0, 0)
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want, 1'b1);
    end

    // random pairs with noise beats mixed in
    while (pairs_sent < RAND_PAIRS) begin
      if (!paused && pairs_sent == PAUSE_AT) begin
        paused = 1'b1;
        while (cipher_q.size() != 0) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
      end
      it = random_beat(is_pair);
      send_beat(it, 1'b0, '0, !(pairs_sent >= 600 && pairs_sent < 900));
      if (is_pair) pairs_sent++;
    end
    in_valid <= 1'b0;

    // drain, then leave room for any stray beat
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && cipher_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: playfair_cipher_encrypt_unit.f
rtl/pf_pkg.sv
rtl/pf_lane.sv
rtl/pf_merge.sv
rtl/pf_rule.sv
rtl/playfair_cipher_encrypt_unit.sv
tb/playfair_cipher_encrypt_unit_tb.sv
